// ----- rtl/core/work_stealing_deque_assert.svh -----
// ----------------------------------------------------------------------------
// work_stealing_deque_assert.svh
// Assertion macros for the work-stealing deque. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_DEQUE_ASSERT_SVH
`define WORK_STEALING_DEQUE_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked at every edge outside reset
`define WSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wsd assertion failed");
// antecedent now, consequent in the following cycle
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsd assertion failed");
`else
`define WSD_ASSERT(lbl, clk, rst_n, prop)
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the work-stealing deque.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned HANDLE_W       = 32;
  localparam int unsigned OCC_W          = 8;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_STEAL = 2'd2
  } wsd_cmd_e;

  typedef struct packed {
    wsd_cmd_e              command;
    logic [HANDLE_W-1:0]   task_handle;
  } wsd_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]   task_out;
    logic                  task_taken;
    logic                  push_rejected;
    logic                  now_empty;
    logic [OCC_W-1:0]      occupancy;
  } wsd_rsp_t;

  // result status known at accept time; handle arrives from the ring memory
  typedef struct packed {
    logic                  task_taken;
    logic                  push_rejected;
    logic                  now_empty;
    logic [OCC_W-1:0]      occupancy;
  } wsd_stat_t;

endpackage

// ----- rtl/core/work_stealing_deque.sv -----
// ----------------------------------------------------------------------------
// work_stealing_deque
// Ring-buffer work-stealing deque of 32-bit task handles.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (push / pop / steal plus handle) is taken on req_i at a
//   clock edge where start is high and busy is low. busy never rises, so one
//   command may be issued every cycle.
//   Each command yields exactly one result word on rsp_o, marked by done_o,
//   in the cycle after acceptance. The receiver has no back-pressure; the word
//   is valid for that single cycle only.
//   Throughput: 1 word per cycle; the result handle comes from the registered
//   read port of the slot memory. Pointers update at acceptance, so a pop
//   right after a push reads the slot written on the previous edge.
//   A push with RING_DEPTH-1 entries held is dropped with push_rejected set.
//   Pop or steal on an empty deque returns task_taken low and a zero handle.
//   Reset clears head, tail and fill count; slot contents are not cleared
//   and need no clearing pass since no slot is read before it is written.
// ----------------------------------------------------------------------------
`include "work_stealing_deque_assert.svh"

module work_stealing_deque #(
  parameter int unsigned RING_DEPTH = wsd_pkg::RING_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  wsd_pkg::wsd_req_t  req_i,
  output logic               done_o,
  output wsd_pkg::wsd_rsp_t  rsp_o
);
  import wsd_pkg::*;

  localparam int unsigned IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic                accept;
  logic                wr_en, rd_en;
  logic [IdxW-1:0]     wr_addr, rd_addr;
  logic [HANDLE_W-1:0] wr_data, rd_data;
  logic                valid;
  wsd_stat_t           stat;
  logic [IdxW-1:0]     head, tail, count;
  logic [IdxW-1:0]     span;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  wsd_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IdxW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (req_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .valid_o   (valid),
    .stat_o    (stat),
    .head_o    (head),
    .tail_o    (tail),
    .count_o   (count)
  );

  wsd_ring_mem #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign done_o              = valid;
  assign rsp_o.task_out      = stat.task_taken ? rd_data : '0;
  assign rsp_o.task_taken    = stat.task_taken;
  assign rsp_o.push_rejected = stat.push_rejected;
  assign rsp_o.now_empty     = stat.now_empty;
  assign rsp_o.occupancy     = stat.occupancy;

  // pointer distance modulo the ring depth, for checking the fill count
  assign span = (tail >= head) ? IdxW'(tail - head)
                               : IdxW'(RING_DEPTH - 32'(head) + 32'(tail));

  `WSD_ASSERT_NEXT(a_one_cycle_latency, clk_i, rst_ni, accept, done_o)
  `WSD_ASSERT(a_count_matches_ptrs, clk_i, rst_ni, count == span)
  `WSD_ASSERT(a_taken_xor_rejected, clk_i, rst_ni, !(done_o && stat.task_taken && stat.push_rejected))
  `WSD_ASSERT(a_empty_zero_occ, clk_i, rst_ni, !(done_o && rsp_o.now_empty) || rsp_o.occupancy == '0)

endmodule

// ----- rtl/core/wsd_ring_mem.sv -----
// ----------------------------------------------------------------------------
// wsd_ring_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wsd_ring_mem #(
  parameter int unsigned RING_DEPTH = wsd_pkg::RING_DEPTH_DEF,
  parameter int unsigned IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [IDX_W-1:0]              wr_addr_i,
  input  logic [wsd_pkg::HANDLE_W-1:0]  wr_data_i,
  input  logic                          rd_en_i,
  input  logic [IDX_W-1:0]              rd_addr_i,
  output logic [wsd_pkg::HANDLE_W-1:0]  rd_data_o
);
  import wsd_pkg::*;

  logic [HANDLE_W-1:0] mem_q [RING_DEPTH];
  logic [HANDLE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/wsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// wsd_ctrl
// Head/tail pointers and fill count; issues ring accesses and result status.
// ----------------------------------------------------------------------------
module wsd_ctrl #(
  parameter int unsigned RING_DEPTH = wsd_pkg::RING_DEPTH_DEF,
  parameter int unsigned IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  wsd_pkg::wsd_req_t             req_i,
  output logic                          wr_en_o,
  output logic [IDX_W-1:0]              wr_addr_o,
  output logic [wsd_pkg::HANDLE_W-1:0]  wr_data_o,
  output logic                          rd_en_o,
  output logic [IDX_W-1:0]              rd_addr_o,
  output logic                          valid_o,
  output wsd_pkg::wsd_stat_t            stat_o,
  output logic [IDX_W-1:0]              head_o,
  output logic [IDX_W-1:0]              tail_o,
  output logic [IDX_W-1:0]              count_o
);
  import wsd_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(RING_DEPTH - 1);

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic             valid_q;
  wsd_stat_t        stat_q, stat_d;

  logic [IDX_W-1:0]       tail_next, tail_prev, head_next;
  logic [IDX_W+OCC_W-1:0] occ_ext;

  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? LastIdx : tail_q - 1'b1;
  assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    wr_en_o   = 1'b0;
    wr_addr_o = tail_q;
    wr_data_o = req_i.task_handle;
    rd_en_o   = 1'b0;
    rd_addr_o = head_q;
    stat_d    = '0;
    if (accept_i) begin
      unique case (req_i.command)
        CMD_PUSH: begin
          if (count_q == LastIdx) begin
            stat_d.push_rejected = 1'b1;
          end else begin
            wr_en_o = 1'b1;
            tail_d  = tail_next;
            count_d = count_q + 1'b1;
          end
        end
        CMD_POP: begin
          if (count_q != '0) begin
            rd_en_o           = 1'b1;
            rd_addr_o         = tail_prev;
            tail_d            = tail_prev;
            count_d           = count_q - 1'b1;
            stat_d.task_taken = 1'b1;
          end
        end
        CMD_STEAL: begin
          if (count_q != '0) begin
            rd_en_o           = 1'b1;
            head_d            = head_next;
            count_d           = count_q - 1'b1;
            stat_d.task_taken = 1'b1;
          end
        end
        default: begin
          // unused code: no operation, status only
        end
      endcase
    end
    occ_ext          = {{OCC_W{1'b0}}, count_d};
    stat_d.now_empty = (count_d == '0);
    stat_d.occupancy = occ_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stat_q <= stat_d;
    end
  end

  assign valid_o = valid_q;
  assign stat_o  = stat_q;
  assign head_o  = head_q;
  assign tail_o  = tail_q;
  assign count_o = count_q;

endmodule
